@@ rtl/core/rhc_pkg.sv @@
// Shared types, fixed-point constants and helpers for the RGB/HSL converter.
// No dependencies; used by rgb_hsl_converter.
package rhc_pkg;

  localparam int FRAC_BITS     = 12;
  localparam int HUE_FRAC_BITS = 6;

  // Codes and scale factors
  localparam int ONE_CODE  = (1 << FRAC_BITS) - 1;           // 4095
  localparam int HUE_SIXTY = 60 << HUE_FRAC_BITS;            // 3840
  localparam int HUE_FULL  = 360 << HUE_FRAC_BITS;           // 23040
  localparam int CH_DEN    = ONE_CODE * HUE_SIXTY;           // channel divisor
  localparam int CH_HALF   = CH_DEN / 2;

  // Datapath widths
  localparam int CH_W  = 12;
  localparam int HUE_W = 15;
  localparam int REM_W = 37;   // widest dividend (channel numerator)
  localparam int DEN_W = 24;
  localparam int Q_W   = 15;   // quotient bits, one divider stage each

  typedef enum logic {
    DIR_RGB2HSL = 1'b0,
    DIR_HSL2RGB = 1'b1
  } dir_t;

  localparam logic [2:0] REG_DIRECTION = 3'd0;

  // Per-item control travelling with the data
  typedef struct packed {
    dir_t            dir;
    logic            grey;
    logic            szero;
    logic [CH_W-1:0] third;   // lightness out (RGB->HSL) or L in (HSL->RGB)
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   q;
  } dlane_t;

  // Piecewise ramp of hue2rgb, in units of hue codes (0..HUE_SIXTY)
  function automatic logic [CH_W-1:0] ramp_k(input logic [HUE_W-1:0] t);
    logic [HUE_W-1:0] k;
    if (t < HUE_W'(HUE_SIXTY)) begin
      k = t;
    end else if (t < HUE_W'(3 * HUE_SIXTY)) begin
      k = HUE_W'(HUE_SIXTY);
    end else if (t < HUE_W'(4 * HUE_SIXTY)) begin
      k = HUE_W'(4 * HUE_SIXTY) - t;
    end else begin
      k = '0;
    end
    return k[CH_W-1:0];
  endfunction

endpackage

@@ rtl/core/rgb_hsl_converter.sv @@
// Streaming RGB <-> HSL converter, direction set over the APB-style port.
// Depends on rhc_pkg.
//
//  channel | direction | ports                      | content
//  --------+-----------+----------------------------+-------------------------------
//  in      | slave     | in_tvalid/in_tready/tdata  | colour request (R,G,B or H,S,L)
//  out     | master    | out_tvalid/out_tready/tdata| converted colour
//  cfg     | APB slave | cfg_p*                     | direction register at 0x0
//
// One request per clock while no stall on out_tready holds the pipeline. It has three
// preparation stages (extrema, products, numerators), one multiply-add stage, fifteen restoring
// divider stages (one quotient bit each, three lanes) and the output register.
// rst_n (synchronous) clears the valid bits and the direction register.
// A stall on out_tready freezes every stage; nothing is lost or repeated.
module rgb_hsl_converter (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [14:0] in_first, [26:15] in_second, [38:27] in_third, [39] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  // out_tdata: [14:0] out_first, [26:15] out_second, [38:27] out_third, [39] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW = rhc_pkg::CH_W;
  localparam int HW = rhc_pkg::HUE_W;
  localparam int RW = rhc_pkg::REM_W;
  localparam int DW = rhc_pkg::DEN_W;
  localparam int QW = rhc_pkg::Q_W;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  rhc_pkg::dir_t dir_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= rhc_pkg::DIR_RGB2HSL;
    end else if (cfg_wr && cfg_paddr == rhc_pkg::REG_DIRECTION) begin
      dir_r <= rhc_pkg::dir_t'(cfg_pwdata[0]);
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == rhc_pkg::REG_DIRECTION) begin
      cfg_prdata = {31'd0, dir_r};
    end
  end

  // Whole pipeline advances together; the output register frees on take-up.
  logic pipe_en;
  logic out_vld_r;
  assign pipe_en   = !out_vld_r || out_tready;
  assign in_tready = pipe_en;

  // ---------------------------------------------------------------------------
  // Stage A: clamp, extrema, hue sextant numerator, hue wrap
  // ---------------------------------------------------------------------------
  logic [HW-1:0] in_a;
  logic [CW-1:0] in_r, in_g, in_b, mx, mn, dd;
  logic [12:0]   sum, sden;
  logic [13:0]   lt;
  logic [HW-1:0] nn, hmod;

  assign in_a = in_tdata[14:0];
  assign in_g = in_tdata[26:15];
  assign in_b = in_tdata[38:27];

  always_comb begin
    in_r = (in_a > HW'(rhc_pkg::ONE_CODE)) ? CW'(rhc_pkg::ONE_CODE) : in_a[CW-1:0];
    hmod = (in_a >= HW'(rhc_pkg::HUE_FULL)) ? in_a - HW'(rhc_pkg::HUE_FULL) : in_a;
    mx = in_r;
    mn = in_r;
    if (in_g > mx) mx = in_g;
    if (in_b > mx) mx = in_b;
    if (in_g < mn) mn = in_g;
    if (in_b < mn) mn = in_b;
    sum = 13'(mx) + 13'(mn);
    dd  = mx - mn;
    lt  = (14'(sum) + 14'd1) >> 1;
    sden = (sum > 13'(rhc_pkg::ONE_CODE)) ? 13'(2 * rhc_pkg::ONE_CODE) - sum : sum;
    // hue in sixths of a turn, times the spread; the sum is never negative
    if (mx == in_r) begin
      if (in_g >= in_b) nn = HW'(in_g - in_b);
      else              nn = HW'(6) * HW'(dd) - HW'(in_b - in_g);
    end else if (mx == in_g) begin
      nn = HW'(2) * HW'(dd) + HW'(in_b) - HW'(in_r);
    end else begin
      nn = HW'(4) * HW'(dd) + HW'(in_r) - HW'(in_g);
    end
  end

  logic          a_vld_r;
  rhc_pkg::side_t a_side_r;
  logic [CW-1:0] a_d_r, a_s_r;
  logic [12:0]   a_sden_r;
  logic [HW-1:0] a_n_r, a_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (pipe_en) begin
      a_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      a_side_r.dir   <= dir_r;
      a_side_r.grey  <= (mx == mn);
      a_side_r.szero <= (in_g == '0);
      a_side_r.third <= (dir_r == rhc_pkg::DIR_RGB2HSL) ? lt[CW-1:0] : in_b;
      a_d_r    <= dd;
      a_s_r    <= in_g;
      a_sden_r <= sden;
      a_n_r    <= nn;
      a_h_r    <= hmod;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: products (q and p scaled by ONE_CODE^2), ramp positions
  // ---------------------------------------------------------------------------
  logic [24:0]   qn_nxt, pnr_nxt;
  logic [15:0]   t0_wide;
  logic [HW-1:0] t0, t2;
  logic [CW-1:0] l_b;

  assign l_b = a_side_r.third;

  always_comb begin
    if ((13'(l_b) << 1) < 13'(rhc_pkg::ONE_CODE)) begin
      qn_nxt = 25'(l_b) * (25'(rhc_pkg::ONE_CODE) + 25'(a_s_r));
    end else begin
      qn_nxt = (25'(l_b) + 25'(a_s_r)) * 25'(rhc_pkg::ONE_CODE) - 25'(l_b) * 25'(a_s_r);
    end
    pnr_nxt = 25'(l_b) * 25'(2 * rhc_pkg::ONE_CODE);
    // red leads by 120 degrees, blue lags by 120
    t0_wide = 16'(a_h_r) + 16'(2 * rhc_pkg::HUE_SIXTY);
    t0 = (t0_wide > 16'(rhc_pkg::HUE_FULL)) ?
         HW'(t0_wide - 16'(rhc_pkg::HUE_FULL)) : t0_wide[HW-1:0];
    t2 = (a_h_r >= HW'(2 * rhc_pkg::HUE_SIXTY)) ?
         a_h_r - HW'(2 * rhc_pkg::HUE_SIXTY) :
         a_h_r + HW'(rhc_pkg::HUE_FULL - 2 * rhc_pkg::HUE_SIXTY);
  end

  logic          b_vld_r;
  rhc_pkg::side_t b_side_r;
  logic [26:0]   b_hnum_r;
  logic [23:0]   b_snum_r;
  logic [CW-1:0] b_d_r;
  logic [12:0]   b_sden_r;
  logic [24:0]   b_qn_r, b_pnr_r;
  logic [CW-1:0] b_k_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (pipe_en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      b_side_r <= a_side_r;
      b_hnum_r <= 27'(a_n_r) * 27'(rhc_pkg::HUE_SIXTY);
      b_snum_r <= 24'(a_d_r) * 24'(rhc_pkg::ONE_CODE);
      b_d_r    <= a_d_r;
      b_sden_r <= a_sden_r;
      b_qn_r   <= qn_nxt;
      b_pnr_r  <= pnr_nxt;
      b_k_r[0] <= rhc_pkg::ramp_k(t0);
      b_k_r[1] <= rhc_pkg::ramp_k(a_h_r);
      b_k_r[2] <= rhc_pkg::ramp_k(t2);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: rounding bias added, divisor chosen per lane
  // ---------------------------------------------------------------------------
  logic [24:0] pn, qn2;

  always_comb begin
    pn  = (b_pnr_r > b_qn_r) ? b_pnr_r - b_qn_r : '0;
    qn2 = (b_qn_r < pn) ? pn : b_qn_r;
  end

  logic          c_vld_r;
  rhc_pkg::side_t c_side_r;
  logic [RW-1:0] c_base_r [0:2];
  logic [DW-1:0] c_den_r  [0:2];
  logic [CW-1:0] c_k_r    [0:2];
  logic [24:0]   c_diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (pipe_en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      c_side_r <= b_side_r;
      if (b_side_r.dir == rhc_pkg::DIR_RGB2HSL) begin
        // lane 0 hue, lane 1 saturation, lane 2 idle
        c_base_r[0] <= RW'(b_hnum_r) + RW'(b_d_r >> 1);
        c_den_r[0]  <= DW'(b_d_r);
        c_base_r[1] <= RW'(b_snum_r) + RW'(b_sden_r >> 1);
        c_den_r[1]  <= DW'(b_sden_r);
        c_base_r[2] <= '0;
        c_den_r[2]  <= DW'(1);
        c_diff_r    <= '0;
        for (int i = 0; i < 3; i++) c_k_r[i] <= '0;
      end else begin
        for (int i = 0; i < 3; i++) begin
          c_base_r[i] <= RW'(pn) * RW'(rhc_pkg::HUE_SIXTY) + RW'(rhc_pkg::CH_HALF);
          c_den_r[i]  <= DW'(rhc_pkg::CH_DEN);
          c_k_r[i]    <= b_k_r[i];
        end
        c_diff_r <= qn2 - pn;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: p + (q - p) * k, loads the divider
  // ---------------------------------------------------------------------------
  logic           dv_vld_r  [0:QW];
  rhc_pkg::side_t dv_side_r [0:QW];
  rhc_pkg::dlane_t dv_r     [0:QW][0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (pipe_en) begin
      dv_vld_r[0] <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dv_side_r[0] <= c_side_r;
      for (int i = 0; i < 3; i++) begin
        dv_r[0][i].rem <= c_base_r[i] + RW'(c_diff_r) * RW'(c_k_r[i]);
        dv_r[0][i].den <= c_den_r[i];
        dv_r[0][i].q   <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider: one quotient bit per stage, MSB first
  // ---------------------------------------------------------------------------
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int BIT = QW - 1 - j;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else if (pipe_en) begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
    end

    for (genvar ln = 0; ln < 3; ln++) begin : g_lane
      logic [RW+1:0] sh, rx;
      logic          take;

      assign sh   = (RW+2)'(dv_r[j][ln].den) << BIT;
      assign rx   = (RW+2)'(dv_r[j][ln].rem);
      assign take = (rx >= sh);

      always_ff @(posedge clk) begin
        if (pipe_en) begin
          dv_r[j+1][ln].den <= dv_r[j][ln].den;
          dv_r[j+1][ln].rem <= take ? RW'(rx - sh) : dv_r[j][ln].rem;
          dv_r[j+1][ln].q   <= dv_r[j][ln].q | (QW'(take) << BIT);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        dv_side_r[j+1] <= dv_side_r[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output: wrap, saturate, special cases
  // ---------------------------------------------------------------------------
  rhc_pkg::side_t fs;
  logic [QW-1:0]  q0, q1, q2;
  logic [HW-1:0]  o1_nxt;
  logic [CW-1:0]  o2_nxt, o3_nxt;

  assign fs = dv_side_r[QW];
  assign q0 = dv_r[QW][0].q;
  assign q1 = dv_r[QW][1].q;
  assign q2 = dv_r[QW][2].q;

  function automatic logic [CW-1:0] sat_one(input logic [QW-1:0] v);
    return (v > QW'(rhc_pkg::ONE_CODE)) ? CW'(rhc_pkg::ONE_CODE) : v[CW-1:0];
  endfunction

  always_comb begin
    if (fs.dir == rhc_pkg::DIR_RGB2HSL) begin
      o3_nxt = fs.third;
      if (fs.grey) begin
        o1_nxt = '0;
        o2_nxt = '0;
      end else begin
        // a hue rounding up to the full circle reads as zero
        o1_nxt = (q0 >= QW'(rhc_pkg::HUE_FULL)) ? q0 - QW'(rhc_pkg::HUE_FULL) : q0;
        o2_nxt = sat_one(q1);
      end
    end else if (fs.szero) begin
      o1_nxt = HW'(fs.third);
      o2_nxt = fs.third;
      o3_nxt = fs.third;
    end else begin
      o1_nxt = HW'(sat_one(q0));
      o2_nxt = sat_one(q1);
      o3_nxt = sat_one(q2);
    end
  end

  logic [HW-1:0] out1_r;
  logic [CW-1:0] out2_r, out3_r;
  rhc_pkg::dir_t out_dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (pipe_en) begin
      out_vld_r <= dv_vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out1_r    <= o1_nxt;
      out2_r    <= o2_nxt;
      out3_r    <= o3_nxt;
      out_dir_r <= fs.dir;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out3_r, out2_r, out1_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_dir_r == rhc_pkg::DIR_RGB2HSL |-> out1_r < HW'(rhc_pkg::HUE_FULL))
    else $error("hue out of range");

  a_red_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_dir_r == rhc_pkg::DIR_HSL2RGB |-> out1_r <= HW'(rhc_pkg::ONE_CODE))
    else $error("red channel above full scale");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld_r[QW] && dv_r[QW][0].den != '0 |-> dv_r[QW][0].rem < RW'(dv_r[QW][0].den))
    else $error("divider remainder not reduced");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(dv_vld_r[0]) && $stable(c_vld_r) && $stable(out1_r))
    else $error("pipeline moved during stall");

endmodule
